@@ hdl/tfq_pkg.sv @@
// Package for the timestamped frame queue.
// Shared widths, operation codes and the controller/datapath interface structs.
// No dependencies.
package tfq_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int HANDLE_W = 32;
    localparam int DIM_W    = 14;
    localparam int TIME_W   = 48;
    localparam int CAP_W    = 5;
    localparam int OCC_W    = 5;
    localparam int MODE_W   = 2;
    localparam int FLAG_W   = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam int IN_FIELDS_W  = HANDLE_W + 2 * DIM_W + 2 * TIME_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = HANDLE_W + 2 * DIM_W + TIME_W + OCC_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH  = 2'd0,
        MODE_GET   = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NOP   = 2'd3
    } t_mode;

    typedef struct packed {
        logic [TIME_W-1:0]   ftime;
        logic [HANDLE_W-1:0] handle;
        logic [DIM_W-1:0]    width;
        logic [DIM_W-1:0]    height;
    } t_entry;

    typedef struct packed {
        logic capture;
        logic push;
        logic clear;
        logic rd;
        logic pop;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        t_mode mode;
        logic  count_zero;
        logic  qualify;
        logic  last_entry;
        logic  out_free;
    } t_dp_status;

endpackage

@@ hdl/timestamped_frame_queue.sv @@
// Timestamped frame queue: a bounded FIFO of frame descriptors (handle, width,
// height, timestamp) that is pushed, drained against a playhead, or cleared.
// One transaction in, one result transaction out. A push, a clear, an unused
// mode or a get on an empty queue goes from execute straight to the result
// load. Any other get reads the head entry and pops entries while they are due,
// until it pops the last queued entry or meets one timed past the playhead.
// The queue is walked through its single memory read port one entry per cycle.
// The input is ready again in the cycle after the result is loaded, so the next
// transaction may enter while the previous result still waits on the output.
// Capacity is to be written only while the block is idle; the block itself does
// not enforce this. Zero acts as one and values above QUEUE_DEPTH saturate.
// Depends on tfq_pkg, tfq_controller and tfq_datapath.
module timestamped_frame_queue import tfq_pkg::*; #(
    parameter int QUEUE_DEPTH = DEPTH_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // frame_handle, frame_width, frame_height, frame_time, playhead_time, zero fill
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // mode
    input  logic [MODE_W-1:0]     s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // shown_handle, shown_width, shown_height, shown_time, occupancy, zero fill
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // push_accepted, frame_found
    output logic [FLAG_W-1:0]     m_axis_tuser,
    input  logic                  i_cfg_wr_en,
    input  logic [CAP_W-1:0]      i_cfg_wr_data
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    tfq_controller u_controller (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    tfq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tuser     (s_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_m_tready    (m_axis_tready),
        .o_m_tvalid    (m_axis_tvalid),
        .o_m_tdata     (m_axis_tdata),
        .o_m_tuser     (m_axis_tuser)
    );

endmodule

@@ hdl/tfq_controller.sv @@
// Sequencer for the timestamped frame queue.
// Steps one transaction through execute, drain and result load.
// Depends on tfq_pkg.
module tfq_controller import tfq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_CHECK,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready  = 1'b1;
                o_cmd.capture = i_s_tvalid;
                if (i_s_tvalid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_OUT;
                unique case (i_status.mode)
                    MODE_PUSH:  o_cmd.push = 1'b1;
                    MODE_CLEAR: o_cmd.clear = 1'b1;
                    MODE_GET: begin
                        if (!i_status.count_zero) begin
                            o_cmd.rd = 1'b1;
                            n_state  = S_CHECK;
                        end
                    end
                    default: ;
                endcase
            end
            S_CHECK: begin
                if (i_status.qualify) begin
                    o_cmd.pop = 1'b1;
                    if (i_status.last_entry) begin
                        n_state = S_OUT;
                    end else begin
                        o_cmd.rd = 1'b1;
                    end
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ hdl/tfq_datapath.sv @@
// Datapath for the timestamped frame queue: descriptor memory, pointers,
// capacity register, latch and output register.
// Depends on tfq_pkg.
module tfq_datapath import tfq_pkg::*; #(
    parameter int QUEUE_DEPTH = DEPTH_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic [MODE_W-1:0]     i_s_tuser,
    input  logic                  i_cfg_wr_en,
    input  logic [CAP_W-1:0]      i_cfg_wr_data,
    input  logic                  i_m_tready,
    output logic                  o_m_tvalid,
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic [FLAG_W-1:0]     o_m_tuser
);

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = IW + 1;
    localparam int EW = (CW > CAP_W) ? CW : CAP_W;
    localparam logic [IW-1:0] LAST_IDX  = IW'(QUEUE_DEPTH - 1);
    localparam logic [SW-1:0] DEPTH_SUM = SW'(QUEUE_DEPTH);
    localparam logic [EW-1:0] DEPTH_EXT = EW'(QUEUE_DEPTH);

    t_entry r_mem [QUEUE_DEPTH];
    t_entry r_rd_data;
    t_entry r_latch;
    t_entry r_in_entry;

    t_mode             r_mode;
    logic [TIME_W-1:0] r_playhead;
    logic [IW-1:0]     r_head;
    logic [CW-1:0]     r_count;
    logic [CAP_W-1:0]  r_cap;
    logic              r_accepted;
    logic              r_found;
    logic              r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [FLAG_W-1:0]     r_out_flags;

    logic [IW-1:0] head_inc;
    logic [SW-1:0] tail_sum;
    logic [IW-1:0] tail_idx;
    logic [IW-1:0] rd_addr;
    logic [EW-1:0] cnt_ext;
    logic [EW-1:0] cap_ext;
    logic          room;
    logic          push_ok;

    assign head_inc = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
    assign tail_sum = SW'(r_head) + SW'(r_count);
    assign tail_idx = (tail_sum >= DEPTH_SUM) ? IW'(tail_sum - DEPTH_SUM) : IW'(tail_sum);
    assign rd_addr  = i_cmd.pop ? head_inc : r_head;
    assign cnt_ext  = EW'(r_count);
    assign cap_ext  = EW'(r_cap);
    assign room     = (cnt_ext < DEPTH_EXT) &&
                      ((r_cap == '0) ? (r_count == '0) : (cnt_ext < cap_ext));
    assign push_ok  = i_cmd.push && room;

    assign o_status.mode       = r_mode;
    assign o_status.count_zero = (r_count == '0);
    assign o_status.qualify    = (r_rd_data.ftime <= r_playhead);
    assign o_status.last_entry = (r_count == CW'(1));
    assign o_status.out_free   = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_flags;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[tail_idx] <= r_in_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode            <= t_mode'(i_s_tuser);
            r_in_entry.handle <= i_s_tdata[HANDLE_W-1:0];
            r_in_entry.width  <= i_s_tdata[HANDLE_W +: DIM_W];
            r_in_entry.height <= i_s_tdata[HANDLE_W + DIM_W +: DIM_W];
            r_in_entry.ftime  <= i_s_tdata[HANDLE_W + 2 * DIM_W +: TIME_W];
            r_playhead        <= i_s_tdata[HANDLE_W + 2 * DIM_W + TIME_W +: TIME_W];
        end
        if (i_cmd.load_out) begin
            r_out_data  <= OUT_DATA_W'({OCC_W'(r_count), r_latch.ftime, r_latch.height,
                                        r_latch.width, r_latch.handle});
            r_out_flags <= {r_found, r_accepted};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_cap       <= CAP_RESET;
            r_accepted  <= 1'b0;
            r_found     <= 1'b0;
            r_latch     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            if (i_cmd.capture) begin
                r_accepted <= 1'b0;
                r_found    <= 1'b0;
            end
            if (push_ok) begin
                r_count    <= r_count + 1'b1;
                r_accepted <= 1'b1;
            end
            if (i_cmd.clear) begin
                r_count <= '0;
                r_head  <= '0;
            end
            if (i_cmd.pop) begin
                r_latch <= r_rd_data;
                r_head  <= head_inc;
                r_count <= r_count - 1'b1;
                r_found <= 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

@@ hdl/tfq_checker.sv @@
// Port-level checks for the timestamped frame queue, bound to the top level.
// Depends on tfq_pkg.
module tfq_checker import tfq_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [FLAG_W-1:0]     m_axis_tuser
);

    a_reset_no_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("push accepted and frame found in one result");

    a_push_occupied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |->
            (m_axis_tdata[OUT_FIELDS_W-1 -: OCC_W] != '0))
        else $error("accepted push left the queue empty");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind timestamped_frame_queue tfq_checker u_tfq_checker (.*);

@@ sim/timestamped_frame_queue_tb.sv @@
`timescale 1ns / 100ps
// Testbench for timestamped_frame_queue: push, get, clear and idle transactions with
// random stalls on both stream sides, checked against a frame queue predictor.
// Depends on tfq_pkg and the timestamped_frame_queue RTL.
module timestamped_frame_queue_tb;
    import tfq_pkg::*;

    localparam int DEPTH      = DEPTH_DEFAULT;
    localparam int IDLE_LIMIT = 2000;
    localparam int LONG_HOLD  = 300;
    localparam int EXP_SLOTS  = 16;
    localparam int OFS_WIDTH  = HANDLE_W;
    localparam int OFS_HEIGHT = OFS_WIDTH + DIM_W;
    localparam int OFS_TIME   = OFS_HEIGHT + DIM_W;
    localparam int OFS_OCC    = OFS_TIME + TIME_W;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef struct packed {
        logic               accepted;
        logic               found;
        t_entry             shown;
        logic [OCC_W-1:0]   occ;
    } t_frame_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [MODE_W-1:0]     s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [FLAG_W-1:0]     m_axis_tuser;
    logic                  i_cfg_wr_en;
    logic [CAP_W-1:0]      i_cfg_wr_data;

    t_entry           queued_frames [DEPTH];
    int               q_head;
    int               q_count;
    t_entry           latched_frame;
    logic [CAP_W-1:0] capacity_reg;
    t_frame_result    exp_fifo [EXP_SLOTS];
    int               exp_wr;
    int               exp_rd;

    logic [TIME_W-1:0] stream_time;
    bit                no_idle;
    int                hold_request;
    int                stalled_cycles;
    int                error_count;
    bit                results_missing;
    int                items_sent;
    int                results_checked;
    int                frames_shown;
    int                pushes_refused;

    timestamped_frame_queue #(
        .QUEUE_DEPTH (DEPTH)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    task automatic advance_frame_queue(input t_mode op, input t_entry frame,
                                       input logic [TIME_W-1:0] playhead,
                                       output t_frame_result res);
        int limit;
        limit = (capacity_reg == 0) ? 1 : ((capacity_reg > DEPTH) ? DEPTH : int'(capacity_reg));
        res = '0;
        case (op)
            MODE_PUSH: begin
                if (q_count < limit) begin
                    queued_frames[(q_head + q_count) % DEPTH] = frame;
                    q_count++;
                    res.accepted = 1'b1;
                end else begin
                    pushes_refused++;
                end
            end
            MODE_GET: begin
                while (q_count > 0 && queued_frames[q_head].ftime <= playhead) begin
                    latched_frame = queued_frames[q_head];
                    q_head = (q_head + 1) % DEPTH;
                    q_count--;
                    res.found = 1'b1;
                end
                if (res.found)
                    frames_shown++;
            end
            MODE_CLEAR: begin
                q_count = 0;
                q_head = 0;
            end
            default: ;
        endcase
        res.shown = latched_frame;
        res.occ = q_count[OCC_W-1:0];
    endtask

    function automatic logic [TIME_W-1:0] rand_time();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[TIME_W-1:0];
    endfunction

    function automatic t_entry rand_frame(input logic [TIME_W-1:0] ftime);
        t_entry f;
        f.handle = $urandom;
        f.width = DIM_W'($urandom_range(0, 16383));
        f.height = DIM_W'($urandom_range(0, 16383));
        f.ftime = ftime;
        return f;
    endfunction

    task automatic send_frame_op(input t_mode op, input t_entry frame,
                                 input logic [TIME_W-1:0] playhead);
        int gap;
        t_frame_result res;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata <= {{(IN_DATA_W - IN_FIELDS_W){1'b0}}, playhead, frame.ftime,
                         frame.height, frame.width, frame.handle};
        s_axis_tuser <= op;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        @(negedge i_clk);
        advance_frame_queue(op, frame, playhead, res);
        exp_fifo[exp_wr % EXP_SLOTS] = res;
        exp_wr++;
        items_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (exp_wr != exp_rd)
            @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] value);
        drain_results();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        capacity_reg = value;
    endtask

    task automatic compare_field(input string name, input logic [63:0] exp_v,
                                 input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
            error_count++;
        end
    endtask

    task automatic check_frame_result();
        t_frame_result exp;
        if (exp_wr == exp_rd) begin
            $error("result transaction with no expectation pending");
            error_count++;
            return;
        end
        exp = exp_fifo[exp_rd % EXP_SLOTS];
        exp_rd++;
        results_checked++;
        compare_field("push_accepted", 64'(exp.accepted), 64'(m_axis_tuser[0]));
        compare_field("frame_found", 64'(exp.found), 64'(m_axis_tuser[1]));
        compare_field("shown_handle", 64'(exp.shown.handle),
                      64'(m_axis_tdata[0 +: HANDLE_W]));
        compare_field("shown_width", 64'(exp.shown.width),
                      64'(m_axis_tdata[OFS_WIDTH +: DIM_W]));
        compare_field("shown_height", 64'(exp.shown.height),
                      64'(m_axis_tdata[OFS_HEIGHT +: DIM_W]));
        compare_field("shown_time", 64'(exp.shown.ftime),
                      64'(m_axis_tdata[OFS_TIME +: TIME_W]));
        compare_field("occupancy", 64'(exp.occ), 64'(m_axis_tdata[OFS_OCC +: OCC_W]));
    endtask

    initial begin : result_sink
        int stall;
        bit long_hold_done;
        long_hold_done = 1'b0;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_request > 0 && !long_hold_done) begin
                stall = hold_request;
                long_hold_done = 1'b1;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 8);
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid)
                @(posedge i_clk);
            check_frame_result();
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stalled_cycles <= 0;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
            if (stalled_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic test_directed();
        t_entry zero_f;
        t_entry ones_f;
        zero_f = '0;
        ones_f = '1;
        send_frame_op(MODE_GET, zero_f, TIME_MAX);
        send_frame_op(MODE_PUSH, zero_f, '0);
        send_frame_op(MODE_PUSH, ones_f, '0);
        send_frame_op(MODE_PUSH, rand_frame(48'h0000_1234_5678), '0);
        send_frame_op(MODE_NOP, ones_f, TIME_MAX);
        send_frame_op(MODE_GET, ones_f, '0);
        send_frame_op(MODE_GET, zero_f, TIME_MAX - 1);
        send_frame_op(MODE_GET, zero_f, TIME_MAX);
        send_frame_op(MODE_GET, ones_f, TIME_MAX);
        send_frame_op(MODE_PUSH, rand_frame(48'd100), '0);
        send_frame_op(MODE_CLEAR, ones_f, TIME_MAX);
        send_frame_op(MODE_GET, ones_f, TIME_MAX);
        send_frame_op(MODE_PUSH, rand_frame(48'd5), '0);
        send_frame_op(MODE_GET, zero_f, 48'd5);
        send_frame_op(MODE_CLEAR, zero_f, '0);
    endtask

    task automatic test_capacity();
        t_entry zero_f;
        zero_f = '0;
        set_capacity(5'd0);
        send_frame_op(MODE_PUSH, rand_frame(48'd10), '0);
        send_frame_op(MODE_PUSH, rand_frame(48'd20), '0);
        send_frame_op(MODE_GET, zero_f, TIME_MAX);
        set_capacity(5'd31);
        for (int i = 0; i < DEPTH + 1; i++)
            send_frame_op(MODE_PUSH, rand_frame(48'(i * 10)), '0);
        set_capacity(5'd4);
        send_frame_op(MODE_PUSH, rand_frame(48'd500), '0);
        send_frame_op(MODE_GET, zero_f, 48'(12 * 10));
        send_frame_op(MODE_PUSH, rand_frame(48'd600), '0);
        send_frame_op(MODE_PUSH, rand_frame(48'd700), '0);
        send_frame_op(MODE_CLEAR, zero_f, '0);
        set_capacity(5'd16);
    endtask

    task automatic send_stream(input int n, input int push_pct);
        int r;
        t_entry f;
        logic [TIME_W-1:0] ph;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < push_pct) begin
                if ($urandom_range(0, 9) == 0) begin
                    f = rand_frame(rand_time());
                end else begin
                    stream_time = stream_time + TIME_W'($urandom_range(1, 4000));
                    f = rand_frame(stream_time);
                end
                send_frame_op(MODE_PUSH, f, rand_time());
            end else if (r < 94) begin
                if ($urandom_range(0, 9) == 0)
                    ph = rand_time();
                else
                    ph = stream_time - TIME_W'($urandom_range(0, 6000));
                send_frame_op(MODE_GET, rand_frame(rand_time()), ph);
            end else if (r < 97) begin
                send_frame_op(MODE_CLEAR, rand_frame(rand_time()), rand_time());
            end else if (r < 99) begin
                send_frame_op(MODE_NOP, rand_frame(rand_time()), rand_time());
            end else begin
                send_frame_op(t_mode'($urandom_range(0, 3)), rand_frame(rand_time()),
                              rand_time());
            end
        end
    endtask

    task automatic test_random_phases();
        int caps [7];
        caps = '{16, 1, 0, 2, 31, 5, 16};
        caps[6] = $urandom_range(3, 15);
        for (int p = 0; p < 7; p++) begin
            set_capacity(CAP_W'(caps[p]));
            no_idle = (p == 2);
            send_stream(220, (p % 2 == 0) ? 55 : 75);
            no_idle = 1'b0;
        end
    endtask

    task automatic test_backpressure();
        drain_results();
        hold_request = LONG_HOLD;
        send_stream(40, 85);
        drain_results();
        send_stream(40, 55);
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = MODE_NOP;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        q_head = 0;
        q_count = 0;
        latched_frame = '0;
        capacity_reg = CAP_RESET;
        no_idle = 1'b0;
        hold_request = 0;
        results_missing = 1'b0;
        items_sent = 0;
        frames_shown = 0;
        pushes_refused = 0;
        stream_time = rand_time();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_capacity();
        test_random_phases();
        test_backpressure();

        drain_results();
        repeat (DEPTH + 8) @(negedge i_clk);
        if (exp_wr != exp_rd) begin
            $error("%0d expected results never arrived", exp_wr - exp_rd);
            results_missing = 1'b1;
        end

        $display("Sent %0d transactions, checked %0d results over capacities 0 to 31,",
                 items_sent, results_checked);
        $display("with %0d gets showing a frame and %0d pushes refused on a full queue.",
                 frames_shown, pushes_refused);
        if (error_count == 0 && !results_missing)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
